>>> rtl/imm_pkg.sv
// Shared types, sizes and helper functions of the integer matrix multiply block.
// Used by imm_store, imm_mac and int_matrix_multiply; depends on nothing else.
package imm_pkg;

   // Matrix geometry.
   localparam int MAX_DIM = 16;
   localparam int DIM_W   = $clog2(MAX_DIM);
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SIZE_W  = 5;
   localparam int DATA_W  = 32;
   localparam int CSR_W   = 2;

   // Request modes.
   localparam logic [1:0] MODE_WRITE_A = 2'd0;
   localparam logic [1:0] MODE_WRITE_B = 2'd1;
   localparam logic [1:0] MODE_QUERY   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_W-1:0] CSR_A_ROWS     = 2'd0;
   localparam logic [CSR_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_W-1:0] CSR_B_COLS     = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

   // Write and read controls towards the element stores.
   typedef struct packed {
      logic              we_a;
      logic              we_b;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic              rd_en;
      logic [ADDR_W-1:0] a_raddr;
      logic [ADDR_W-1:0] b_raddr;
   } store_ctl_type;

   // Controls towards the multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctl_type;

   // Element address: row-major with a fixed pitch of MAX_DIM.
   function automatic logic [ADDR_W-1:0] elem_addr(input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] c);
      elem_addr = ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
   endfunction

   // A size register saturated to the matrix capacity.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      eff_size = (s > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : s;
   endfunction

endpackage

>>> rtl/imm_store.sv
// Element stores for matrices A and B, one word per element, registered reads.
// Depends on imm_pkg for geometry and the store control struct.
module imm_store (
   input  logic                          clock,
   input  imm_pkg::store_ctl_type        ctl,
   output logic [imm_pkg::DATA_W-1:0]    a_rdata,
   output logic [imm_pkg::DATA_W-1:0]    b_rdata
);

   logic [imm_pkg::DATA_W-1:0] a_mem [imm_pkg::DEPTH];
   logic [imm_pkg::DATA_W-1:0] b_mem [imm_pkg::DEPTH];
   logic [imm_pkg::DATA_W-1:0] a_rdata_ff;
   logic [imm_pkg::DATA_W-1:0] b_rdata_ff;

   // Matrix A: one write port, one read port.
   always_ff @(posedge clock) begin
      if (ctl.we_a) begin
         a_mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.rd_en) begin
         a_rdata_ff <= a_mem[ctl.a_raddr];
      end
   end

   // Matrix B: one write port, one read port.
   always_ff @(posedge clock) begin
      if (ctl.we_b) begin
         b_mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.rd_en) begin
         b_rdata_ff <= b_mem[ctl.b_raddr];
      end
   end

   assign a_rdata = a_rdata_ff;
   assign b_rdata = b_rdata_ff;

endmodule

>>> rtl/imm_mac.sv
// Shared multiply-accumulate unit: a registered 32-bit product, then a wrapping sum.
// Depends on imm_pkg for the data width and the control struct.
module imm_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  imm_pkg::mac_ctl_type          ctl,
   input  logic [imm_pkg::DATA_W-1:0]    a_data,
   input  logic [imm_pkg::DATA_W-1:0]    b_data,
   output logic [imm_pkg::DATA_W-1:0]    acc,
   output logic                          pending
);

   logic [imm_pkg::DATA_W-1:0] prod_ff;
   logic [imm_pkg::DATA_W-1:0] prod_in;
   logic                       prod_valid_ff;
   logic [imm_pkg::DATA_W-1:0] acc_ff;
   logic [imm_pkg::DATA_W-1:0] acc_in;

   // Only the low word of the product is kept, so signedness does not matter.
   assign prod_in = imm_pkg::DATA_W'(a_data * b_data);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   // Product stage valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.valid;
      end
   end

   // Product and accumulator words.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc     = acc_ff;
   assign pending = prod_valid_ff;

endmodule

>>> rtl/int_matrix_multiply.sv
// Top level of the integer matrix multiply block: sequencer, size registers, result port.
// Depends on imm_pkg, imm_store and imm_mac.
//
// Usage. A request is taken on a rising edge with start high and busy low.
// Mode 0 writes req_value into A at (req_row, req_col), mode 1 into B; writes
// outside the configured sizes are dropped, and writes give no result. Busy
// stays low for a write, so writes may follow back to back. Mode 2 queries
// element (req_row, req_col) of C = A x B. The sequencer walks the inner
// dimension through one shared multiply-accumulate unit, issuing one read of
// each store per cycle; the read, product and sum stages add latency. While a
// query in range runs, busy is high. A query out of range, or one with an
// inner size of zero, answers in the cycle after it. Each result is shown on
// rsp_product and rsp_index_error for one cycle with rsp_valid high; the
// receiver cannot stall it. Configuration must be written through csr_we,
// csr_index and csr_data while no query runs; the block itself does not
// enforce this. Reset sets all three sizes to 16, clears the sequencer and
// the strobe; element stores are not cleared.
module int_matrix_multiply (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [3:0]                    req_row,
   input  logic [3:0]                    req_col,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_product,
   output logic                          rsp_index_error,
   input  logic                          csr_we,
   input  logic [imm_pkg::CSR_W-1:0]     csr_index,
   input  logic [imm_pkg::SIZE_W-1:0]    csr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [imm_pkg::SIZE_W-1:0]   a_rows_ff, inner_ff, b_cols_ff;
   logic [imm_pkg::SIZE_W-1:0]   ar, kn, bc;
   logic [imm_pkg::DIM_W-1:0]    row_ff, row_in, col_ff, col_in;
   logic [imm_pkg::SIZE_W-1:0]   k_ff, k_in, kn_ff, kn_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [imm_pkg::DATA_W-1:0]   rsp_product_ff, rsp_product_in;
   logic                         rsp_error_ff, rsp_error_in;
   logic                         accept;
   logic                         row_in_a, col_in_a, row_in_b, col_in_b;
   logic                         issue;
   logic                         mac_pending;
   logic [imm_pkg::DATA_W-1:0]   a_rdata, b_rdata, acc;
   imm_pkg::store_ctl_type       store_ctl;
   imm_pkg::mac_ctl_type         mac_ctl;

   assign ar = imm_pkg::eff_size(a_rows_ff);
   assign kn = imm_pkg::eff_size(inner_ff);
   assign bc = imm_pkg::eff_size(b_cols_ff);

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Range checks on the request indexes.
   assign row_in_a = {1'b0, req_row} < ar;
   assign col_in_a = {1'b0, req_col} < kn;
   assign row_in_b = {1'b0, req_row} < kn;
   assign col_in_b = {1'b0, req_col} < bc;

   // One term is read in each cycle of the run state.
   assign issue = (state_ff == ST_RUN);

   // Store controls: writes come straight from an accepted request.
   always_comb begin
      store_ctl.we_a    = accept && (req_mode == imm_pkg::MODE_WRITE_A) && row_in_a && col_in_a;
      store_ctl.we_b    = accept && (req_mode == imm_pkg::MODE_WRITE_B) && row_in_b && col_in_b;
      store_ctl.waddr   = imm_pkg::elem_addr(req_row, req_col);
      store_ctl.wdata   = req_value;
      store_ctl.rd_en   = issue;
      store_ctl.a_raddr = imm_pkg::elem_addr(row_ff, k_ff[imm_pkg::DIM_W-1:0]);
      store_ctl.b_raddr = imm_pkg::elem_addr(k_ff[imm_pkg::DIM_W-1:0], col_ff);
   end

   // The accumulator is cleared on every accepted request, so a query starts its run from zero.
   always_comb begin
      mac_ctl.clear = accept;
      mac_ctl.valid = rd_valid_ff;
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      k_in           = k_ff;
      kn_in          = kn_ff;
      rd_valid_in    = issue;
      rsp_valid_in   = 1'b0;
      rsp_product_in = rsp_product_ff;
      rsp_error_in   = rsp_error_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == imm_pkg::MODE_QUERY)) begin
               row_in = req_row;
               col_in = req_col;
               k_in   = '0;
               kn_in  = kn;
               if (!(row_in_a && col_in_b)) begin
                  // Out of range: answer zero with the error flag.
                  rsp_valid_in   = 1'b1;
                  rsp_product_in = '0;
                  rsp_error_in   = 1'b1;
               end else if (kn == '0) begin
                  // Empty dot product.
                  rsp_valid_in   = 1'b1;
                  rsp_product_in = '0;
                  rsp_error_in   = 1'b0;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            k_in = k_ff + 1'b1;
            if (k_in == kn_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait until the last term has gone through the product and sum.
            if (!rd_valid_ff && !mac_pending) begin
               rsp_valid_in   = 1'b1;
               rsp_product_in = acc;
               rsp_error_in   = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Size registers; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= imm_pkg::SIZE_RESET;
         inner_ff  <= imm_pkg::SIZE_RESET;
         b_cols_ff <= imm_pkg::SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            imm_pkg::CSR_A_ROWS:     a_rows_ff <= csr_data;
            imm_pkg::CSR_INNER_SIZE: inner_ff  <= csr_data;
            imm_pkg::CSR_B_COLS:     b_cols_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Query payload and result words.
   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      col_ff         <= col_in;
      k_ff           <= k_in;
      kn_ff          <= kn_in;
      rsp_product_ff <= rsp_product_in;
      rsp_error_ff   <= rsp_error_in;
   end

   imm_store u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .a_rdata (a_rdata),
      .b_rdata (b_rdata)
   );

   imm_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .a_data  (a_rdata),
      .b_data  (b_rdata),
      .acc     (acc),
      .pending (mac_pending)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_product     = rsp_product_ff;
   assign rsp_index_error = rsp_error_ff;

endmodule
